/* src/swrr_pkg.sv */
// Shared types, register codes and constants for the SWR ratio block.
// No dependencies; the RTL files refer to this package by scoped names, the testbench imports it.
package swrr_pkg;

    // Default sizing
    localparam int SAMPLE_BITS     = 12;
    localparam int RATIO_FRAC_BITS = 8;

    // Field widths of the channels
    localparam int SMP_W    = 12;
    localparam int LEVEL_W  = 12;
    localparam int RATIO_W  = 16;

    // Register widths
    localparam int WEIGHT_W    = 9;
    localparam int WEIGHT_FRAC = 8;
    localparam int MIN_FWD_W   = 12;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 9'd256;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_WEIGHT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REFLECTED_WEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_FORWARD      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RATIO        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FORMULA_MODE     = 3'd4;

    // Register reset values
    localparam logic [WEIGHT_W-1:0]   RST_FORWARD_WEIGHT   = 9'd128;
    localparam logic [WEIGHT_W-1:0]   RST_REFLECTED_WEIGHT = 9'd128;
    localparam logic [MIN_FWD_W-1:0]  RST_MIN_FORWARD      = 12'd0;
    localparam logic [RATIO_W-1:0]    RST_MAX_RATIO        = 16'd6400;
    localparam logic                  RST_FORMULA_MODE     = 1'b1;

    typedef struct packed {
        logic [SMP_W-1:0] forward_sample;
        logic [SMP_W-1:0] reflected_sample;
    } t_in_item;

    typedef struct packed {
        logic [RATIO_W-1:0] swr_ratio;
        logic [LEVEL_W-1:0] forward_level;
        logic [LEVEL_W-1:0] reflected_level;
    } t_out_item;

    typedef struct packed {
        logic [WEIGHT_W-1:0]  forward_weight;
        logic [WEIGHT_W-1:0]  reflected_weight;
        logic [MIN_FWD_W-1:0] min_forward;
        logic [RATIO_W-1:0]   max_ratio;
        logic                 formula_mode;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SMOOTH_F,
        ST_SMOOTH_R,
        ST_CLASSIFY,
        ST_SQRT,
        ST_DIV_LOAD,
        ST_DIV,
        ST_FINISH
    } t_state;

    typedef enum logic [1:0] {
        KIND_ONE,
        KIND_CAP,
        KIND_CALC
    } t_kind;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic smooth_fwd;
        logic smooth_ref;
        logic classify;
        logic sqrt_step;
        logic div_load;
        logic div_step;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic special;
        logic use_sqrt;
    } t_dp_sts;

endpackage

/* src/swrr_ctrl.sv */
// Sequencer for the SWR ratio block: state machine and step counter.
// Depends on swrr_pkg; drives swrr_dp through t_dp_cmd.
module swrr_ctrl #(
    parameter int SAMPLE_BITS     = swrr_pkg::SAMPLE_BITS,
    parameter int RATIO_FRAC_BITS = swrr_pkg::RATIO_FRAC_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_out_free,
    output logic              o_finish,
    input  swrr_pkg::t_dp_sts i_sts,
    output swrr_pkg::t_dp_cmd o_cmd
);

    localparam int Q_W   = SAMPLE_BITS + 2 + RATIO_FRAC_BITS;
    localparam int CNT_W = $clog2(Q_W);

    swrr_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= swrr_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            swrr_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = swrr_pkg::ST_SMOOTH_F;
            end
            swrr_pkg::ST_SMOOTH_F: n_state = swrr_pkg::ST_SMOOTH_R;
            swrr_pkg::ST_SMOOTH_R: n_state = swrr_pkg::ST_CLASSIFY;
            swrr_pkg::ST_CLASSIFY: begin
                if (i_sts.special) begin
                    n_state = swrr_pkg::ST_FINISH;
                end else if (i_sts.use_sqrt) begin
                    n_state = swrr_pkg::ST_SQRT;
                    n_cnt   = CNT_W'(SAMPLE_BITS - 1);
                end else begin
                    n_state = swrr_pkg::ST_DIV_LOAD;
                end
            end
            swrr_pkg::ST_SQRT: begin
                if (r_cnt == '0) n_state = swrr_pkg::ST_DIV_LOAD;
                else             n_cnt   = r_cnt - 1'b1;
            end
            swrr_pkg::ST_DIV_LOAD: begin
                n_state = swrr_pkg::ST_DIV;
                n_cnt   = CNT_W'(Q_W - 1);
            end
            swrr_pkg::ST_DIV: begin
                if (r_cnt == '0) n_state = swrr_pkg::ST_FINISH;
                else             n_cnt   = r_cnt - 1'b1;
            end
            swrr_pkg::ST_FINISH: begin
                if (i_out_free) n_state = swrr_pkg::ST_IDLE;
            end
            default: n_state = swrr_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        o_finish   = 1'b0;
        case (r_state)
            swrr_pkg::ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            swrr_pkg::ST_SMOOTH_F: o_cmd.smooth_fwd = 1'b1;
            swrr_pkg::ST_SMOOTH_R: o_cmd.smooth_ref = 1'b1;
            swrr_pkg::ST_CLASSIFY: o_cmd.classify   = 1'b1;
            swrr_pkg::ST_SQRT:     o_cmd.sqrt_step  = 1'b1;
            swrr_pkg::ST_DIV_LOAD: o_cmd.div_load   = 1'b1;
            swrr_pkg::ST_DIV:      o_cmd.div_step   = 1'b1;
            swrr_pkg::ST_FINISH:   o_finish         = i_out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

/* src/swrr_dp.sv */
// Datapath of the SWR ratio block: averages, bit-serial square root,
// restoring divider and final clamp. Depends on swrr_pkg.
module swrr_dp #(
    parameter int SAMPLE_BITS     = swrr_pkg::SAMPLE_BITS,
    parameter int RATIO_FRAC_BITS = swrr_pkg::RATIO_FRAC_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  swrr_pkg::t_in_item  i_in,
    input  swrr_pkg::t_cfg      i_cfg,
    input  swrr_pkg::t_dp_cmd   i_cmd,
    output swrr_pkg::t_dp_sts   o_sts,
    output swrr_pkg::t_out_item o_result
);

    localparam int S        = SAMPLE_BITS;
    localparam int F        = RATIO_FRAC_BITS;
    localparam int Q_W      = S + 2 + F;
    localparam int RAD_W    = 2 * S;
    localparam int WF       = swrr_pkg::WEIGHT_FRAC;
    localparam int WEIGHT_W = swrr_pkg::WEIGHT_W;
    localparam int MIN_W    = swrr_pkg::MIN_FWD_W;
    localparam int CMP_W    = (S > MIN_W) ? S : MIN_W;
    localparam int RATIO_W  = swrr_pkg::RATIO_W;
    localparam int LEVEL_W  = swrr_pkg::LEVEL_W;
    localparam int V_W      = (Q_W > RATIO_W) ? Q_W : RATIO_W;
    localparam logic [V_W-1:0] ONE_V = V_W'(1) << F;

    logic [S-1:0]     r_fs, r_rs;
    logic [S-1:0]     r_favg, r_ravg;
    swrr_pkg::t_kind  r_kind;
    logic [RAD_W-1:0] r_rad;
    logic [S+1:0]     r_srem;
    logic [S-1:0]     r_root;
    logic [Q_W-1:0]   r_dq;
    logic [S-1:0]     r_drem;
    logic [S-1:0]     r_dden;

    // Shared smoothing multiplier: avg' = avg + w * (sample - avg) / 256
    logic [WEIGHT_W-1:0]     w_raw, w_sat;
    logic [S-1:0]            m_smp, m_avg, m_new;
    logic signed [S:0]       m_diff;
    logic signed [S+10:0]    m_prod, m_sum;

    always_comb begin
        w_raw  = i_cmd.smooth_ref ? i_cfg.reflected_weight : i_cfg.forward_weight;
        m_smp  = i_cmd.smooth_ref ? r_rs   : r_fs;
        m_avg  = i_cmd.smooth_ref ? r_ravg : r_favg;
        w_sat  = (w_raw > swrr_pkg::WEIGHT_ONE) ? swrr_pkg::WEIGHT_ONE : w_raw;
        m_diff = $signed({1'b0, m_smp}) - $signed({1'b0, m_avg});
        m_prod = m_diff * $signed({1'b0, w_sat});
        m_sum  = $signed({3'b000, m_avg, {WF{1'b0}}}) + m_prod;
        m_new  = m_sum[S+WF-1:WF];
    end

    // Classification of the new averages
    swrr_pkg::t_kind kind_now;
    always_comb begin
        if (r_ravg == '0 || CMP_W'(r_favg) < CMP_W'(i_cfg.min_forward))
            kind_now = swrr_pkg::KIND_ONE;
        else if (r_ravg >= r_favg)
            kind_now = swrr_pkg::KIND_CAP;
        else
            kind_now = swrr_pkg::KIND_CALC;
    end

    assign o_sts.special  = (kind_now != swrr_pkg::KIND_CALC);
    assign o_sts.use_sqrt = i_cfg.formula_mode;

    // Square root step: two radicand bits in, one root bit out
    logic [S+3:0] sq_tmp, sq_trial;
    logic         sq_ge;
    always_comb begin
        sq_tmp   = {r_srem, r_rad[RAD_W-1 -: 2]};
        sq_trial = {2'b00, r_root, 2'b01};
        sq_ge    = (sq_tmp >= sq_trial);
    end

    // Divider step: one quotient bit
    logic [S:0]   dv_t;
    logic         dv_ge;
    logic [S+1:0] num;
    always_comb begin
        dv_t  = {r_drem, r_dq[Q_W-1]};
        dv_ge = (dv_t >= {1'b0, r_dden});
        num   = (S+2)'(r_favg) + (S+2)'(r_ravg)
              + (i_cfg.formula_mode ? {1'b0, r_root, 1'b0} : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_favg <= '0;
            r_ravg <= '0;
        end else begin
            if (i_cmd.smooth_fwd) r_favg <= m_new;
            if (i_cmd.smooth_ref) r_ravg <= m_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_fs <= S'(i_in.forward_sample);
            r_rs <= S'(i_in.reflected_sample);
        end
        if (i_cmd.classify) begin
            r_kind <= kind_now;
            r_rad  <= RAD_W'(r_favg) * RAD_W'(r_ravg);
            r_srem <= '0;
            r_root <= '0;
        end
        if (i_cmd.sqrt_step) begin
            r_srem <= sq_ge ? (S+2)'(sq_tmp - sq_trial) : (S+2)'(sq_tmp);
            r_root <= {r_root[S-2:0], sq_ge};
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
        end
        if (i_cmd.div_load) begin
            r_dq   <= {num, {F{1'b0}}};
            r_drem <= '0;
            r_dden <= r_favg - r_ravg;
        end
        if (i_cmd.div_step) begin
            r_drem <= dv_ge ? S'(dv_t - {1'b0, r_dden}) : S'(dv_t);
            r_dq   <= {r_dq[Q_W-2:0], dv_ge};
        end
    end

    // Clamp to cap, then raise to 1.0
    logic [V_W-1:0] v_sel, v_cap, v_max, v_fin;
    always_comb begin
        v_max = V_W'(i_cfg.max_ratio);
        case (r_kind)
            swrr_pkg::KIND_ONE:  v_sel = ONE_V;
            swrr_pkg::KIND_CAP:  v_sel = v_max;
            swrr_pkg::KIND_CALC: v_sel = V_W'(r_dq);
            default:             v_sel = ONE_V;
        endcase
        v_cap = (v_sel > v_max) ? v_max : v_sel;
        v_fin = (v_cap < ONE_V) ? ONE_V : v_cap;
    end

    assign o_result.swr_ratio       = RATIO_W'(v_fin);
    assign o_result.forward_level   = LEVEL_W'(r_favg);
    assign o_result.reflected_level = LEVEL_W'(r_ravg);

endmodule

/* src/swr_ratio_from_detector_pair.sv */
// Top level of the SWR ratio block: config registers, output register,
// controller and datapath. Depends on swrr_pkg, swrr_ctrl and swrr_dp.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+--------------------------------
//  in       | input     | i_in_valid/o_in_ready | i_in  (t_in_item: fwd, refl)
//  out      | output    | o_out_valid/i_out_ready| o_out (t_out_item: ratio, levels)
//  cfg      | input     | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
// In power mode a pair runs through the bit-serial square root and then the
// restoring divider, one bit per cycle each; voltage mode skips the square root,
// and a ratio fixed at 1.0 or the cap skips both. A new pair is taken only once
// the controller is back in idle.
// Reset is synchronous, active low; it restores the register defaults and
// clears both averages. A finished result waits in the output register while
// the next pair is taken; only the final load waits on a stalled consumer.
module swr_ratio_from_detector_pair #(
    parameter int SAMPLE_BITS     = swrr_pkg::SAMPLE_BITS,
    parameter int RATIO_FRAC_BITS = swrr_pkg::RATIO_FRAC_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  swrr_pkg::t_in_item                   i_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output swrr_pkg::t_out_item                  o_out,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [swrr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [swrr_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int WEIGHT_W = swrr_pkg::WEIGHT_W;
    localparam int MIN_W    = swrr_pkg::MIN_FWD_W;
    localparam int RATIO_W  = swrr_pkg::RATIO_W;

    swrr_pkg::t_cfg      r_cfg;
    swrr_pkg::t_out_item r_out;
    logic                r_out_valid;
    swrr_pkg::t_dp_cmd   cmd;
    swrr_pkg::t_dp_sts   sts;
    swrr_pkg::t_out_item result;
    logic                finish;
    logic                out_free;

    // Config writes are always taken; unknown indexes drop
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.forward_weight   <= swrr_pkg::RST_FORWARD_WEIGHT;
            r_cfg.reflected_weight <= swrr_pkg::RST_REFLECTED_WEIGHT;
            r_cfg.min_forward      <= swrr_pkg::RST_MIN_FORWARD;
            r_cfg.max_ratio        <= swrr_pkg::RST_MAX_RATIO;
            r_cfg.formula_mode     <= swrr_pkg::RST_FORMULA_MODE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                swrr_pkg::CFG_FORWARD_WEIGHT:   r_cfg.forward_weight   <= WEIGHT_W'(i_cfg_data);
                swrr_pkg::CFG_REFLECTED_WEIGHT: r_cfg.reflected_weight <= WEIGHT_W'(i_cfg_data);
                swrr_pkg::CFG_MIN_FORWARD:      r_cfg.min_forward      <= MIN_W'(i_cfg_data);
                swrr_pkg::CFG_MAX_RATIO:        r_cfg.max_ratio        <= RATIO_W'(i_cfg_data);
                swrr_pkg::CFG_FORMULA_MODE:     r_cfg.formula_mode     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Output register: load on finish, drop once the beat is taken
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) r_out <= result;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    swrr_ctrl #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_out_free (out_free),
        .o_finish   (finish),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    swrr_dp #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (r_cfg),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_result (result)
    );

endmodule

/* tb/testbench.sv */
// Self-checking testbench for swr_ratio_from_detector_pair: SWR ratio and smoothed levels.
// Depends on swrr_pkg (beat types, register codes, reset values) and the block's RTL.
// An in-file predictor tracks both averages and the registers; every output beat is checked.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import swrr_pkg::*;

    // Cycle budget: far above the slowest correct run (about 1100 pairs,
    // plus random gaps, stalls and one long output hold-off).
    localparam int unsigned RUN_LIMIT   = 600_000;
    // Cycles to keep watching after the last result.
    localparam int unsigned TAIL_CYCLES = 100;
    // Length of the long receiver hold-off.
    localparam int unsigned HOLD_CYCLES = 400;
    // Top register index; every index above CFG_FORMULA_MODE is unmapped.
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_INDEX = '1;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_reg_write;

    // Stimulus side, all driven to known values from time zero.
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    t_in_item              in_beat   = '0;
    logic                  out_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic                  in_ready;
    logic                  out_valid;
    logic                  cfg_ready;
    t_out_item             out_beat;

    // Predictor state: a copy of the registers and of both averages.
    t_cfg                  regs_model;
    logic [LEVEL_W-1:0]    fwd_level;
    logic [LEVEL_W-1:0]    ref_level;

    // Results predicted at input acceptance, oldest first.
    t_out_item             pending_results[$];
    t_out_item             head_result;
    // Register writes waiting for the next idle window.
    t_reg_write            reg_batch[$];

    int unsigned           fail_count     = 0;
    int unsigned           cycle_count    = 0;
    int unsigned           src_idle_pct   = 0;
    int unsigned           sink_stall_pct = 0;
    int unsigned           hold_requests  = 0;
    int unsigned           holds_served   = 0;
    int unsigned           hold_left      = 0;

    swr_ratio_from_detector_pair dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_beat),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // 2 ns clock.
    initial begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // One exponential-average update; weights above 1.0 saturate to 1.0.
    function automatic logic [LEVEL_W-1:0] ema_step(logic [LEVEL_W-1:0] avg,
                                                    logic [SMP_W-1:0] smp,
                                                    logic [WEIGHT_W-1:0] weight);
        int unsigned full;
        int unsigned w;
        full = WEIGHT_ONE;
        w    = (weight > WEIGHT_ONE) ? full : weight;
        return LEVEL_W'((w * smp + (full - w) * avg) >> WEIGHT_FRAC);
    endfunction

    // Floor square root, bit by bit from the top; the operand stays below 2^24.
    function automatic int unsigned floor_root(int unsigned v);
        int unsigned root;
        int unsigned trial;
        root = 0;
        for (int b = 15; b >= 0; b--) begin
            trial = root | (32'd1 << b);
            if (trial * trial <= v) root = trial;
        end
        return root;
    endfunction

    // SWR in Q8.8 from the two averages, under the current registers.
    function automatic logic [RATIO_W-1:0] swr_of(int unsigned f, int unsigned r);
        int unsigned unity;
        int unsigned cap;
        int unsigned num;
        int unsigned v;
        unity = 32'd1 << RATIO_FRAC_BITS;
        cap   = regs_model.max_ratio;
        if (r == 0 || f < regs_model.min_forward) begin
            v = unity;
        end else if (r >= f) begin
            v = cap;
        end else begin
            num = f + r;
            // Power formula: (1 + sqrt(r/f)) / (1 - sqrt(r/f)) rewritten over f - r.
            if (regs_model.formula_mode) num += 2 * floor_root(f * r);
            v = (num << RATIO_FRAC_BITS) / (f - r);
        end
        // Apply the cap first, then the floor of 1.0: a cap below 1.0 yields 1.0.
        if (v > cap) v = cap;
        if (v < unity) v = unity;
        return RATIO_W'(v);
    endfunction

    // Advance both averages by one pair and form the expected output beat.
    function automatic t_out_item predict_pair(t_in_item pair);
        t_out_item res;
        fwd_level = ema_step(fwd_level, pair.forward_sample, regs_model.forward_weight);
        ref_level = ema_step(ref_level, pair.reflected_sample, regs_model.reflected_weight);
        res.swr_ratio       = swr_of(fwd_level, ref_level);
        res.forward_level   = fwd_level;
        res.reflected_level = ref_level;
        return res;
    endfunction

    // Mirror one accepted register write; unmapped indexes change nothing.
    function automatic void shadow_write(t_reg_write wr);
        case (wr.index)
            CFG_FORWARD_WEIGHT:   regs_model.forward_weight   = wr.data[WEIGHT_W-1:0];
            CFG_REFLECTED_WEIGHT: regs_model.reflected_weight = wr.data[WEIGHT_W-1:0];
            CFG_MIN_FORWARD:      regs_model.min_forward      = wr.data[MIN_FWD_W-1:0];
            CFG_MAX_RATIO:        regs_model.max_ratio        = wr.data[RATIO_W-1:0];
            CFG_FORMULA_MODE:     regs_model.formula_mode     = wr.data[0];
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one pair, with a random idle gap first; leave valid high on return
    // so that a back-to-back pair keeps the channel busy without a bubble.
    task automatic send_pair(input t_in_item pair);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
        end
        in_valid <= 1'b1;
        in_beat  <= pair;
        do @(posedge clk); while (!in_ready);
        pending_results.push_back(predict_pair(pair));
    endtask

    task automatic send_samples(input int unsigned fwd, input int unsigned refl);
        t_in_item pair;
        pair.forward_sample   = SMP_W'(fwd);
        pair.reflected_sample = SMP_W'(refl);
        send_pair(pair);
    endtask

    // Drop valid and hold until every predicted result has been checked.
    task automatic wait_all_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    function automatic void queue_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        reg_batch.push_back('{index: idx, data: data});
    endfunction

    // Write the queued registers back to back once the block is idle.
    // Callers always advance time before the next batch.
    task automatic program_regs();
        wait_all_results();
        while (reg_batch.size() != 0) begin
            cfg_valid <= 1'b1;
            cfg_index <= reg_batch[0].index;
            cfg_data  <= reg_batch[0].data;
            do @(posedge clk); while (!cfg_ready);
            shadow_write(reg_batch.pop_front());
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(input int unsigned fw, input int unsigned rw,
                            input int unsigned minf, input int unsigned cap,
                            input int unsigned mode);
        queue_reg(CFG_FORWARD_WEIGHT,   CFG_DATA_W'(fw));
        queue_reg(CFG_REFLECTED_WEIGHT, CFG_DATA_W'(rw));
        queue_reg(CFG_MIN_FORWARD,      CFG_DATA_W'(minf));
        queue_reg(CFG_MAX_RATIO,        CFG_DATA_W'(cap));
        queue_reg(CFG_FORMULA_MODE,     CFG_DATA_W'(mode));
        program_regs();
    endtask

    // Random bits above the register width, the value below it.
    function automatic logic [CFG_DATA_W-1:0] with_junk(int unsigned value, int unsigned width);
        logic [CFG_DATA_W-1:0] mask;
        mask = CFG_DATA_W'((32'd1 << width) - 1);
        return (CFG_DATA_W'($urandom) & ~mask) | (CFG_DATA_W'(value) & mask);
    endfunction

    function automatic int unsigned random_weight();
        case ($urandom_range(5))
            0:       return WEIGHT_ONE;
            1:       return $urandom_range(511, 257);   // saturates to 1.0
            2:       return $urandom_range(16, 1);      // slow average
            default: return $urandom_range(256);
        endcase
    endfunction

    task automatic randomize_regs();
        int unsigned minf;
        int unsigned cap;
        case ($urandom_range(4))
            0:       minf = 0;
            1:       minf = 4095;
            2:       minf = $urandom_range(4095);
            default: minf = $urandom_range(64);
        endcase
        case ($urandom_range(6))
            0:       cap = $urandom_range(255);          // cap below 1.0
            1:       cap = 256;
            2:       cap = 65535;
            3:       cap = RST_MAX_RATIO;
            4:       cap = $urandom_range(65535, 256);
            default: cap = $urandom_range(8000, 300);
        endcase
        queue_reg(CFG_FORWARD_WEIGHT,   with_junk(random_weight(), WEIGHT_W));
        queue_reg(CFG_REFLECTED_WEIGHT, with_junk(random_weight(), WEIGHT_W));
        queue_reg(CFG_MIN_FORWARD,      with_junk(minf, MIN_FWD_W));
        queue_reg(CFG_MAX_RATIO,        with_junk(cap, RATIO_W));
        queue_reg(CFG_FORMULA_MODE,     with_junk($urandom_range(1), 1));
        // Sometimes poke an unmapped index; it must change nothing.
        if ($urandom_range(3) == 0)
            queue_reg(CFG_IDX_W'(CFG_LAST_INDEX - $urandom_range(2)),
                      CFG_DATA_W'($urandom));
        program_regs();
    endtask

    // Pairs biased toward the interesting regions of the ratio.
    function automatic t_in_item random_pair();
        t_in_item    pair;
        int unsigned f;
        int unsigned r;
        f = $urandom_range(4095);
        case ($urandom_range(7))
            0: r = 0;
            1: r = $urandom_range(4095, f);              // reflected at or above forward
            2: r = $urandom_range(f / 16);               // good match
            3: r = f - $urandom_range((f < 24) ? f : 24); // near total reflection
            4: begin
                f = $urandom_range(1) ? 4095 : 0;
                r = $urandom_range(1) ? 4095 : $urandom_range(4095);
            end
            default: r = $urandom_range(4095);
        endcase
        pair.forward_sample   = SMP_W'(f);
        pair.reflected_sample = SMP_W'(r);
        return pair;
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus long hold-offs on request
    // ------------------------------------------------------------------

    always @(posedge clk) begin
        if (hold_left != 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_requests != holds_served) begin
            out_ready    <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            holds_served <= holds_served + 1;
        end else begin
            out_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            fail_count++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    // Compare each accepted output beat with the oldest prediction.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                $error("output beat with no pending result: ratio %0d",
                       out_beat.swr_ratio);
            end else begin
                head_result = pending_results.pop_front();
                check_field("swr_ratio", head_result.swr_ratio, out_beat.swr_ratio);
                check_field("forward_level", head_result.forward_level,
                            out_beat.forward_level);
                check_field("reflected_level", head_result.reflected_level,
                            out_beat.reflected_level);
            end
        end
    end

    // Watchdog.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("** swr_ratio_from_detector_pair: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Run with the reset register values and zero averages (weights 0.5, power mode).
    task automatic test_reset_defaults();
        send_samples(4095, 0);
        send_samples(4095, 2048);
        send_samples(0, 4095);
    endtask

    // Extremes and each branch of the ratio, with weights of 1.0 so the
    // averages follow the samples exactly.
    task automatic test_directed_cases();
        set_regs(WEIGHT_ONE, WEIGHT_ONE, 0, RST_MAX_RATIO, 1);
        send_samples(0, 0);          // no reflection: 1.0
        send_samples(4095, 4095);    // reflected equals forward: cap
        send_samples(4095, 1);
        send_samples(4095, 4094);    // huge ratio, clipped to the cap
        send_samples(2, 1);
        // Voltage formula.
        set_regs(WEIGHT_ONE, WEIGHT_ONE, 0, RST_MAX_RATIO, 0);
        send_samples(4095, 1);
        send_samples(3000, 1000);
        send_samples(4095, 4094);
        // Forward below the minimum forces 1.0; at the minimum it does not.
        set_regs(WEIGHT_ONE, WEIGHT_ONE, 4095, RST_MAX_RATIO, 1);
        send_samples(4094, 10);
        send_samples(4095, 10);
        // Cap below 1.0: the floor of 1.0 wins.
        set_regs(WEIGHT_ONE, WEIGHT_ONE, 0, 100, 1);
        send_samples(4095, 4095);
        send_samples(3000, 1000);
        // Widest cap.
        set_regs(WEIGHT_ONE, WEIGHT_ONE, 0, 65535, 0);
        send_samples(4095, 4094);
        send_samples(4095, 0);
    endtask

    // Masking of wide write data, weights above 1.0, unmapped indexes, zero weight.
    task automatic test_register_masking();
        queue_reg(CFG_FORWARD_WEIGHT,   16'hFFFF);   // 511: acts as 1.0
        queue_reg(CFG_REFLECTED_WEIGHT, 16'hFF00);   // low bits 256
        queue_reg(CFG_MIN_FORWARD,      16'hF000);   // low bits 0
        queue_reg(CFG_MAX_RATIO,        16'hFFFF);
        queue_reg(CFG_FORMULA_MODE,     16'hFFFE);   // low bit 0: voltage
        for (int idx = CFG_FORMULA_MODE + 1; idx <= CFG_LAST_INDEX; idx++)
            queue_reg(CFG_IDX_W'(idx), 16'hFFFF);
        program_regs();
        send_samples(1234, 567);
        // Zero weight: both averages hold.
        set_regs(0, 0, 0, RST_MAX_RATIO, 1);
        send_samples(4095, 4095);
        set_regs(1, 1, 0, RST_MAX_RATIO, 1);
        send_samples(4095, 0);
    endtask

    // Hold the receiver off for a long stretch while pairs keep coming, so the
    // output register fills and the block stalls its input.
    task automatic test_output_hold_off();
        randomize_regs();
        src_idle_pct   = 0;
        sink_stall_pct <= 0;
        hold_requests  <= hold_requests + 1;
        repeat (24) send_pair(random_pair());
    endtask

    // Pause the sender mid-stream until every result is back, then resume.
    task automatic test_sender_pause();
        src_idle_pct   = 0;
        sink_stall_pct <= 27;
        repeat (16) send_pair(random_pair());
        wait_all_results();
        repeat (16) send_pair(random_pair());
    endtask

    // Random pairs under one idling profile; reprogram the registers every so often.
    task automatic test_random_phase(input int unsigned src_pct, input int unsigned sink_pct,
                                     input int unsigned n_pairs);
        src_idle_pct   = src_pct;
        sink_stall_pct <= sink_pct;
        for (int i = 0; i < n_pairs; i++) begin
            if (i % 65 == 0) randomize_regs();
            send_pair(random_pair());
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        regs_model = '{forward_weight:   RST_FORWARD_WEIGHT,
                       reflected_weight: RST_REFLECTED_WEIGHT,
                       min_forward:      RST_MIN_FORWARD,
                       max_ratio:        RST_MAX_RATIO,
                       formula_mode:     RST_FORMULA_MODE};
        fwd_level = '0;
        ref_level = '0;

        // Hold reset, then release it once.
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_directed_cases();
        test_register_masking();
        test_output_hold_off();
        test_sender_pause();
        test_random_phase(0, 0, 260);
        test_random_phase(70, 0, 260);
        test_random_phase(0, 70, 260);
        test_random_phase(27, 27, 260);

        // Drain, then watch a little longer for stray beats.
        wait_all_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("** swr_ratio_from_detector_pair: PASSED **");
        end else begin
            $display("** swr_ratio_from_detector_pair: FAILED **");
        end
        $finish;
    end

endmodule
